>>> rtl/lhwf_pkg.sv
`default_nettype none

package lhwf_pkg;

    localparam int MAP_W     = 32;
    localparam int MAP_H     = 32;
    localparam int MAP_DEPTH = MAP_W * MAP_H;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int COORD_W   = 5;
    localparam int EXT_W     = COORD_W + 1;
    localparam int SIZE_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 6;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [EXT_W-1:0]   ext_t;
    typedef logic [ADDR_W-1:0]  map_addr_t;
    typedef logic [1:0]         dir_t;

    localparam dir_t FACE_EAST  = 2'd0;
    localparam dir_t FACE_NORTH = 2'd1;
    localparam dir_t FACE_WEST  = 2'd2;
    localparam dir_t FACE_SOUTH = 2'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAZE_WIDTH  = 3'd0,
        CFG_MAZE_HEIGHT = 3'd1,
        CFG_START_X     = 3'd2,
        CFG_START_Y     = 3'd3,
        CFG_EXIT_X      = 3'd4,
        CFG_EXIT_Y      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic   action;
        coord_t cell_x;
        coord_t cell_y;
        logic   cell_solid;
    } cmd_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        dir_t   heading;
        coord_t target_x;
        coord_t target_y;
        logic   finished;
    } res_t;

    function automatic map_addr_t map_addr(coord_t x, coord_t y);
        map_addr_t a;
        a = ADDR_W'(ADDR_W'(y) * ADDR_W'(MAP_W) + ADDR_W'(x));
        return a;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lhwf_cmd_if.sv
`default_nettype none

interface lhwf_cmd_if import lhwf_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/lhwf_res_if.sv
`default_nettype none

interface lhwf_res_if import lhwf_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/left_hand_wall_follower.sv
`default_nettype none

// Left-hand wall follower on a 32 by 32 solid/open bitmap. Each command transaction either
// writes one maze cell or advances the walker by one step time, and each produces exactly
// one result transaction, registered in the cycle after acceptance, with the walker position,
// heading, next node and a finished flag. The block takes one command per clock with one
// exception: the map memory is read into registers ahead of every decision, so when a step moves
// the next node and leaves the walker in the decide phase (the init step, and a decide step
// that goes straight ahead without reaching the exit), the following cycle is a bubble in
// which no command is taken. A result that is not taken also holds off the next command.
// After reset a sweep clears all 1024 map cells, one cell per cycle, during which
// no command is taken; configuration writes are accepted at any time and are meant to be
// made while idle.
module left_hand_wall_follower
    import lhwf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    lhwf_cmd_if.sink                   cmd,
    lhwf_res_if.source                 res
);

    typedef enum logic [5:0] {
        PH_INIT   = 6'b000001,
        PH_DECIDE = 6'b000010,
        PH_ROTL   = 6'b000100,
        PH_ROTR   = 6'b001000,
        PH_MOVE   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    typedef struct packed {
        coord_t hx;
        coord_t hy;
        coord_t nx;
        coord_t ny;
        dir_t   facing;
        coord_t wx;
        coord_t wy;
        phase_t ph;
    } walk_t;

    function automatic coord_t step_x(coord_t x, dir_t d);
        coord_t r;
        r = x;
        if (d == FACE_EAST)
        begin
            r = COORD_W'(x + 1'b1);
        end
        else if (d == FACE_WEST)
        begin
            r = COORD_W'(x - 1'b1);
        end
        return r;
    endfunction

    function automatic coord_t step_y(coord_t y, dir_t d);
        coord_t r;
        r = y;
        if (d == FACE_SOUTH)
        begin
            r = COORD_W'(y + 1'b1);
        end
        else if (d == FACE_NORTH)
        begin
            r = COORD_W'(y - 1'b1);
        end
        return r;
    endfunction

    function automatic logic faces_next(walk_t s);
        logic f;
        ext_t hx;
        ext_t hy;
        ext_t nx;
        ext_t ny;
        hx = {1'b0, s.hx};
        hy = {1'b0, s.hy};
        nx = {1'b0, s.nx};
        ny = {1'b0, s.ny};
        case (s.facing)
            FACE_EAST:  f = (EXT_W'(hx + 1'b1) == nx) && (hy == ny);
            FACE_WEST:  f = (EXT_W'(nx + 1'b1) == hx) && (hy == ny);
            FACE_NORTH: f = (EXT_W'(ny + 1'b1) == hy) && (hx == nx);
            default:    f = (EXT_W'(hy + 1'b1) == ny) && (hx == nx);
        endcase
        return f;
    endfunction

    function automatic walk_t run_after(walk_t s, coord_t ex, coord_t ey);
        walk_t r;
        logic  at_exit;
        r = s;
        at_exit = (s.nx == ex) && (s.ny == ey);
        case (s.ph)
            PH_ROTL:
            begin
                r.facing = 2'(s.facing + 2'd1);
                if (faces_next(r))
                begin
                    r.ph = PH_MOVE;
                end
            end
            PH_ROTR:
            begin
                r.facing = 2'(s.facing - 2'd1);
                if (faces_next(r))
                begin
                    r.ph = at_exit ? PH_DONE : PH_MOVE;
                end
            end
            PH_MOVE:
            begin
                r.wx = s.nx;
                r.wy = s.ny;
                r.ph = at_exit ? PH_DONE : PH_DECIDE;
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

    logic [SIZE_W-1:0]  maze_width_reg;
    logic [SIZE_W-1:0]  maze_height_reg;
    coord_t             start_x_reg;
    coord_t             start_y_reg;
    coord_t             exit_x_reg;
    coord_t             exit_y_reg;

    walk_t              walk_reg;
    walk_t              walk_next;
    walk_t              dec_st;

    logic               clearing_reg;
    map_addr_t          clr_addr_reg;
    logic               pf_ok_reg;
    logic               pf_ok_next;

    logic               map_ew_mem [MAP_DEPTH];
    logic               map_ns_mem [MAP_DEPTH];
    logic [3:0]         nb_raw_reg;
    logic [3:0]         byp_hit_reg;
    logic               byp_bit_reg;
    logic [3:0]         nb_solid;
    map_addr_t          rd_addr [4];

    logic               mem_we;
    map_addr_t          wr_addr;
    logic               wr_bit;

    logic               res_valid_reg;
    res_t               res_data_reg;
    res_t               res_data_next;

    logic               cmd_fire;
    logic               is_step;
    logic [SIZE_W-1:0]  act_w;
    logic [SIZE_W-1:0]  act_h;
    logic [3:0]         in_bounds;
    logic [3:0]         open_dir;
    dir_t               left_dir;
    dir_t               right_dir;
    ext_t               nx_ext;
    ext_t               ny_ext;
    logic               wr_in_map;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign is_step  = (cmd.data.action == ACT_STEP);

    assign cmd.ready = !clearing_reg && (pf_ok_reg || (walk_reg.ph != PH_DECIDE)) &&
                       (!res_valid_reg || res.ready);

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_width_reg  <= SIZE_W'(32);
            maze_height_reg <= SIZE_W'(32);
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            exit_x_reg      <= COORD_W'(31);
            exit_y_reg      <= COORD_W'(31);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAZE_WIDTH:  maze_width_reg  <= cfg_data;
                CFG_MAZE_HEIGHT: maze_height_reg <= cfg_data;
                CFG_START_X:     start_x_reg     <= cfg_data[COORD_W-1:0];
                CFG_START_Y:     start_y_reg     <= cfg_data[COORD_W-1:0];
                CFG_EXIT_X:      exit_x_reg      <= cfg_data[COORD_W-1:0];
                CFG_EXIT_Y:      exit_y_reg      <= cfg_data[COORD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign act_w = (maze_width_reg > SIZE_W'(MAP_W)) ? SIZE_W'(MAP_W) : maze_width_reg;
    assign act_h = (maze_height_reg > SIZE_W'(MAP_H)) ? SIZE_W'(MAP_H) : maze_height_reg;

    assign nx_ext = {1'b0, walk_reg.nx};
    assign ny_ext = {1'b0, walk_reg.ny};

    always_comb
    begin
        in_bounds[FACE_EAST]  = (EXT_W'(nx_ext + 1'b1) < act_w) && (ny_ext < act_h);
        in_bounds[FACE_WEST]  = (walk_reg.nx != '0) && (EXT_W'(nx_ext - 1'b1) < act_w) &&
                                (ny_ext < act_h);
        in_bounds[FACE_SOUTH] = (EXT_W'(ny_ext + 1'b1) < act_h) && (nx_ext < act_w);
        in_bounds[FACE_NORTH] = (walk_reg.ny != '0) && (EXT_W'(ny_ext - 1'b1) < act_h) &&
                                (nx_ext < act_w);
        for (int d = 0; d < 4; d++)
        begin
            rd_addr[d] = map_addr(step_x(walk_reg.nx, 2'(d)), step_y(walk_reg.ny, 2'(d)));
            nb_solid[d] = byp_hit_reg[d] ? byp_bit_reg : nb_raw_reg[d];
            open_dir[d] = in_bounds[d] && !nb_solid[d];
        end
    end

    // The map is kept twice so that all four neighbors of the next node are read each cycle.
    assign wr_in_map = ({1'b0, cmd.data.cell_x} < EXT_W'(MAP_W)) &&
                       ({1'b0, cmd.data.cell_y} < EXT_W'(MAP_H));
    assign mem_we  = clearing_reg || (cmd_fire && !is_step && wr_in_map);
    assign wr_addr = clearing_reg ? clr_addr_reg : map_addr(cmd.data.cell_x, cmd.data.cell_y);
    assign wr_bit  = clearing_reg ? 1'b0 : cmd.data.cell_solid;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_ew_mem[wr_addr] <= wr_bit;
            map_ns_mem[wr_addr] <= wr_bit;
        end
        nb_raw_reg[FACE_EAST]  <= map_ew_mem[rd_addr[FACE_EAST]];
        nb_raw_reg[FACE_WEST]  <= map_ew_mem[rd_addr[FACE_WEST]];
        nb_raw_reg[FACE_NORTH] <= map_ns_mem[rd_addr[FACE_NORTH]];
        nb_raw_reg[FACE_SOUTH] <= map_ns_mem[rd_addr[FACE_SOUTH]];
    end

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 4; d++)
        begin
            byp_hit_reg[d] <= mem_we && (wr_addr == rd_addr[d]);
        end
        byp_bit_reg <= wr_bit;
    end

    assign left_dir  = 2'(walk_reg.facing + 2'd1);
    assign right_dir = 2'(walk_reg.facing - 2'd1);

    always_comb
    begin
        dec_st = walk_reg;
        if (open_dir[left_dir])
        begin
            dec_st.hx = walk_reg.nx;
            dec_st.hy = walk_reg.ny;
            dec_st.nx = step_x(walk_reg.nx, left_dir);
            dec_st.ny = step_y(walk_reg.ny, left_dir);
            dec_st.ph = PH_ROTL;
        end
        else if (open_dir[walk_reg.facing])
        begin
            dec_st.hx = walk_reg.nx;
            dec_st.hy = walk_reg.ny;
            dec_st.nx = step_x(walk_reg.nx, walk_reg.facing);
            dec_st.ny = step_y(walk_reg.ny, walk_reg.facing);
            dec_st.ph = ((dec_st.nx == exit_x_reg) && (dec_st.ny == exit_y_reg)) ?
                        PH_DONE : PH_MOVE;
        end
        else if (open_dir[right_dir])
        begin
            dec_st.hx = walk_reg.nx;
            dec_st.hy = walk_reg.ny;
            dec_st.nx = step_x(walk_reg.nx, right_dir);
            dec_st.ny = step_y(walk_reg.ny, right_dir);
            dec_st.ph = PH_ROTR;
        end
        else
        begin
            dec_st.hx = walk_reg.nx;
            dec_st.hy = walk_reg.ny;
            dec_st.nx = walk_reg.hx;
            dec_st.ny = walk_reg.hy;
            dec_st.ph = PH_ROTL;
        end
    end

    always_comb
    begin
        walk_next = walk_reg;
        if (cmd_fire && is_step)
        begin
            unique case (walk_reg.ph)
                PH_INIT:
                begin
                    walk_next.hx     = start_x_reg;
                    walk_next.hy     = start_y_reg;
                    walk_next.nx     = start_x_reg;
                    walk_next.ny     = start_y_reg;
                    walk_next.wx     = start_x_reg;
                    walk_next.wy     = start_y_reg;
                    walk_next.facing = FACE_EAST;
                    walk_next.ph     = PH_DECIDE;
                end
                PH_DECIDE:
                begin
                    walk_next = run_after(dec_st, exit_x_reg, exit_y_reg);
                end
                PH_ROTL, PH_ROTR, PH_MOVE:
                begin
                    walk_next = run_after(walk_reg, exit_x_reg, exit_y_reg);
                end
                default:
                begin
                    walk_next = walk_reg;
                end
            endcase
        end
    end

    // The prefetched neighbor bits are stale after any step that moves the next node.
    assign pf_ok_next = !(cmd_fire && is_step &&
                          ((walk_reg.ph == PH_INIT) || (walk_reg.ph == PH_DECIDE)));

    always_comb
    begin
        res_data_next.pos_x    = walk_next.wx;
        res_data_next.pos_y    = walk_next.wy;
        res_data_next.heading  = walk_next.facing;
        res_data_next.target_x = walk_next.nx;
        res_data_next.target_y = walk_next.ny;
        res_data_next.finished = (walk_next.ph == PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg      <= '{hx: '0, hy: '0, nx: '0, ny: '0, facing: FACE_EAST,
                               wx: '0, wy: '0, ph: PH_INIT};
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            pf_ok_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            walk_reg  <= walk_next;
            pf_ok_reg <= pf_ok_next;
            if (clearing_reg)
            begin
                clr_addr_reg <= ADDR_W'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == ADDR_W'(MAP_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cmd_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_data_reg <= res_data_next;
        end
    end

endmodule

`default_nettype wire
